// ===== hdl/vdet_pkg.sv =====
package vdet_pkg;

	localparam int MaxDisks = 16;
	localparam int MaxExtents = 8;
	localparam int DiskW = $clog2(MaxDisks);
	localparam int ExtW = $clog2(MaxExtents);
	localparam int CntW = $clog2(MaxExtents + 1);
	localparam int ExtAddrW = DiskW + ExtW;
	localparam int ExtDepth = MaxDisks * MaxExtents;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_GROW = 3'd1,
		OP_SHRINK = 3'd2,
		OP_DESTROY = 3'd3,
		OP_TRANSLATE = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EXISTS = 3'd1,
		ST_FULL = 3'd2,
		ST_NODISK = 3'd3,
		ST_NOEXT = 3'd4,
		ST_DENIED = 3'd5,
		ST_PASTEND = 3'd6,
		ST_OVERRUN = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_NEXT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [15:0] device_id;
		logic [1:0] mode;
		logic [15:0] phys_device;
		logic [47:0] extent_start;
		logic [31:0] extent_length;
		logic [47:0] sector;
		logic [9:0] count;
		logic access;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] chunks;
		logic [15:0] first_device;
		logic [47:0] first_sector;
		logic [9:0] first_length;
		logic [15:0] second_device;
		logic [47:0] second_sector;
		logic [9:0] second_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] device;
		logic [47:0] base;
		logic [31:0] size;
	} extent_t;

endpackage

// ===== hdl/vdet_extent_ram.sv =====
module vdet_extent_ram (
	input logic clk,
	input logic wr_en,
	input logic [vdet_pkg::ExtAddrW-1:0] wr_addr,
	input vdet_pkg::extent_t wr_data,
	input logic [vdet_pkg::ExtAddrW-1:0] rd_addr,
	output vdet_pkg::extent_t rd_data
);

	vdet_pkg::extent_t mem [vdet_pkg::ExtDepth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/virtual_disk_extent_translator_unit.sv =====
// Create, grow, shrink, destroy and reserved codes pass the match stage and S_DECIDE and
// raise the result in S_DONE; translate walks its at most eight extents in S_WALK, skipping
// those before the sector, and uses S_NEXT when the range crosses into the next extent.
// Throughput: one item at a time; the next item is taken the cycle after the result
// leaves, and each extent read alternates address and data cycles on the memory port.
// Reset: arst_n clears all disk slots and extent counts; extent memory is
// undefined until written.
module virtual_disk_extent_translator_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input vdet_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output vdet_pkg::out_item_t out_data
);

	localparam int DiskW = vdet_pkg::DiskW;
	localparam int ExtW = vdet_pkg::ExtW;
	localparam int CntW = vdet_pkg::CntW;
	localparam int ExtAddrW = vdet_pkg::ExtAddrW;

	vdet_pkg::state_t state_q, state_d;
	vdet_pkg::in_item_t req_q;
	vdet_pkg::out_item_t res_q;

	logic [vdet_pkg::MaxDisks-1:0] valid_q;
	logic [15:0] key_q [vdet_pkg::MaxDisks];
	logic [1:0] mode_q [vdet_pkg::MaxDisks];
	logic [CntW-1:0] ecnt_q [vdet_pkg::MaxDisks];

	logic hit_q, free_any_q;
	logic [DiskW-1:0] hit_idx_q, free_idx_q;
	logic [ExtW:0] e_q;
	logic [48:0] off_q;

	logic hit_c, free_any_c;
	logic [DiskW-1:0] hit_idx_c, free_idx_c;

	logic ram_we;
	logic [ExtAddrW-1:0] ram_waddr, ram_raddr;
	vdet_pkg::extent_t ram_wdata, ram_rdata;

	logic match_s1;
	logic walking;

	// Key match across slots, first hit and first free slot.
	always_comb begin
		hit_c = 1'b0;
		hit_idx_c = '0;
		free_any_c = 1'b0;
		free_idx_c = '0;
		for (int i = vdet_pkg::MaxDisks - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == req_q.device_id) begin
				hit_c = 1'b1;
				hit_idx_c = DiskW'(i);
			end
			if (!valid_q[i]) begin
				free_any_c = 1'b1;
				free_idx_c = DiskW'(i);
			end
		end
	end

	logic [CntW-1:0] n_w;
	logic [1:0] dmode_w;
	logic need_ok;
	logic [48:0] sz_w, fit_w, first_w, second_w;
	logic last_ext;

	always_comb begin
		n_w = ecnt_q[hit_idx_q];
		dmode_w = mode_q[hit_idx_q];
		need_ok = req_q.access ? dmode_w[1] : dmode_w[0];
		sz_w = {17'd0, ram_rdata.size};
		fit_w = off_q + {39'd0, req_q.count};
		first_w = sz_w - off_q;
		second_w = {39'd0, req_q.count} - first_w;
		last_ext = (e_q + 1'b1) >= (ExtW + 1)'(n_w);
	end

	assign in_ready = (state_q == vdet_pkg::S_IDLE);
	assign out_valid = (state_q == vdet_pkg::S_DONE);
	assign out_data = res_q;

	always_comb begin
		ram_raddr = {hit_idx_q, e_q[ExtW-1:0]};
		ram_we = (state_q == vdet_pkg::S_DECIDE) && !match_s1
			&& req_q.opcode == vdet_pkg::OP_GROW
			&& hit_q && n_w < CntW'(vdet_pkg::MaxExtents);
		ram_waddr = {hit_idx_q, n_w[ExtW-1:0]};
		ram_wdata.device = req_q.phys_device;
		ram_wdata.base = req_q.extent_start;
		ram_wdata.size = req_q.extent_length;
	end

	vdet_extent_ram u_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// S_IDLE -> match stage (hit registered) -> S_DECIDE; walk reads extent e_q.
	logic walk_done, walk_adv;
	logic [2:0] walk_status;

	always_comb begin
		walk_done = 1'b0;
		walk_adv = 1'b0;
		walk_status = vdet_pkg::ST_OK;
		if (e_q >= (ExtW + 1)'(n_w) || n_w == '0) begin
			walk_done = 1'b1;
			walk_status = vdet_pkg::ST_PASTEND;
		end else if (off_q < sz_w) begin
			if (fit_w <= sz_w) begin
				walk_done = 1'b1;
			end else if (last_ext) begin
				walk_done = 1'b1;
				walk_status = vdet_pkg::ST_OVERRUN;
			end
		end else begin
			walk_adv = 1'b1;
		end
	end

	vdet_pkg::out_item_t dec_res_w, walk_err_w, next_err_w;

	// Status-only results: every chunk field stays zero.
	always_comb begin
		dec_res_w = '0;
		if (req_q.opcode == vdet_pkg::OP_CREATE) begin
			dec_res_w.status = hit_q ? vdet_pkg::ST_EXISTS
				: (free_any_q ? vdet_pkg::ST_OK : vdet_pkg::ST_FULL);
		end else if (req_q.opcode == vdet_pkg::OP_GROW) begin
			dec_res_w.status = !hit_q ? vdet_pkg::ST_NODISK
				: (ram_we ? vdet_pkg::ST_OK : vdet_pkg::ST_FULL);
		end else if (req_q.opcode == vdet_pkg::OP_SHRINK) begin
			dec_res_w.status = !hit_q ? vdet_pkg::ST_NODISK
				: (n_w == '0 ? vdet_pkg::ST_NOEXT : vdet_pkg::ST_OK);
		end else if (req_q.opcode == vdet_pkg::OP_DESTROY) begin
			dec_res_w.status = hit_q ? vdet_pkg::ST_OK : vdet_pkg::ST_NODISK;
		end else if (req_q.opcode == vdet_pkg::OP_TRANSLATE) begin
			dec_res_w.status = !hit_q ? vdet_pkg::ST_NODISK
				: (need_ok ? vdet_pkg::ST_OK : vdet_pkg::ST_DENIED);
		end
		walk_err_w = '0;
		walk_err_w.status = walk_status;
		next_err_w = '0;
		next_err_w.status = vdet_pkg::ST_OVERRUN;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdet_pkg::S_IDLE: if (in_valid) state_d = vdet_pkg::S_DECIDE;
			vdet_pkg::S_DECIDE: begin
				if (match_s1) state_d = state_q;
				else if (req_q.opcode == vdet_pkg::OP_TRANSLATE && hit_q && need_ok)
					state_d = vdet_pkg::S_WALK;
				else state_d = vdet_pkg::S_DONE;
			end
			vdet_pkg::S_WALK: begin
				if (walking) begin
					if (walk_done && (walk_status != vdet_pkg::ST_OK || fit_w <= sz_w))
						state_d = vdet_pkg::S_DONE;
					else if (walk_done) state_d = vdet_pkg::S_WALK;
					else if (!walk_adv) state_d = vdet_pkg::S_NEXT;
				end
			end
			vdet_pkg::S_NEXT: if (walking) state_d = vdet_pkg::S_DONE;
			vdet_pkg::S_DONE: if (out_ready) state_d = vdet_pkg::S_IDLE;
			default: state_d = vdet_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdet_pkg::S_IDLE;
			valid_q <= '0;
			match_s1 <= 1'b0;
			walking <= 1'b0;
			for (int i = 0; i < vdet_pkg::MaxDisks; i++) ecnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			match_s1 <= (state_q == vdet_pkg::S_IDLE) && in_valid;
			unique case (state_q)
				vdet_pkg::S_DECIDE: begin
					if (!match_s1) begin
						unique case (req_q.opcode)
							vdet_pkg::OP_CREATE: if (!hit_q && free_any_q) begin
								valid_q[free_idx_q] <= 1'b1;
								ecnt_q[free_idx_q] <= '0;
							end
							vdet_pkg::OP_GROW: if (ram_we) ecnt_q[hit_idx_q] <= n_w + 1'b1;
							vdet_pkg::OP_SHRINK: if (hit_q && n_w != '0)
								ecnt_q[hit_idx_q] <= n_w - 1'b1;
							vdet_pkg::OP_DESTROY: if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								ecnt_q[hit_idx_q] <= '0;
							end
							default: ;
						endcase
					end
					walking <= !match_s1;
				end
				// Alternate address and data cycles so each read sees the new index.
				vdet_pkg::S_WALK: walking <= !walking;
				vdet_pkg::S_NEXT: walking <= !walking;
				default: walking <= 1'b0;
			endcase
		end
	end

	// Key and mode writes for create; payload only.
	always_ff @(posedge clk) begin
		if (state_q == vdet_pkg::S_DECIDE && !match_s1 && req_q.opcode == vdet_pkg::OP_CREATE
			&& !hit_q && free_any_q) begin
			key_q[free_idx_q] <= req_q.device_id;
			mode_q[free_idx_q] <= req_q.mode;
		end
	end

	// Datapath: request and match capture, walk offset, extent index, result assembly.
	always_ff @(posedge clk) begin
		if (state_q == vdet_pkg::S_IDLE && in_valid) req_q <= in_data;
		if (match_s1) begin
			hit_q <= hit_c;
			hit_idx_q <= hit_idx_c;
			free_any_q <= free_any_c;
			free_idx_q <= free_idx_c;
		end
		unique case (state_q)
			vdet_pkg::S_DECIDE: begin
				e_q <= '0;
				off_q <= {1'b0, req_q.sector};
				res_q <= dec_res_w;
			end
			vdet_pkg::S_WALK: if (walking) begin
				if (walk_adv) begin
					off_q <= off_q - sz_w;
					e_q <= e_q + 1'b1;
				end else if (walk_done && walk_status != vdet_pkg::ST_OK) begin
					res_q <= walk_err_w;
				end else begin
					res_q.first_device <= ram_rdata.device;
					res_q.first_sector <= ram_rdata.base + off_q[47:0];
					if (fit_w <= sz_w) begin
						res_q.chunks <= 2'd1;
						res_q.first_length <= req_q.count;
					end else begin
						res_q.chunks <= 2'd2;
						res_q.first_length <= first_w[9:0];
						res_q.second_length <= second_w[9:0];
						e_q <= e_q + 1'b1;
					end
				end
			end
			vdet_pkg::S_NEXT: if (walking) begin
				if ({17'd0, ram_rdata.size} < {39'd0, res_q.second_length}) begin
					res_q <= next_err_w;
				end else begin
					res_q.second_device <= ram_rdata.device;
					res_q.second_sector <= ram_rdata.base;
				end
			end
			default: ;
		endcase
	end

endmodule
